// ===== hw/rtl/nnis_pkg.sv =====
// Shared constants, types and helper functions of the nearest-neighbor image scaler.
`timescale 1ns / 1ps

package nnis_pkg;

    localparam int MAX_SOURCE_SIDE = 256;
    localparam int MAX_TARGET_SIDE = 4096;

    localparam int PIXEL_W     = 32;
    localparam int SRC_W       = $clog2(MAX_SOURCE_SIDE) + 1;
    localparam int TGT_W       = $clog2(MAX_TARGET_SIDE) + 1;
    localparam int POS_W       = $clog2(MAX_TARGET_SIDE);
    localparam int SRC_IDX_W   = $clog2(MAX_SOURCE_SIDE);
    localparam int ADDR_W      = 2 * SRC_IDX_W;
    localparam int STORE_DEPTH = MAX_SOURCE_SIDE * MAX_SOURCE_SIDE;
    localparam int PROD_W      = POS_W + SRC_W;
    localparam int SIZE_W      = 2 * SRC_W;
    localparam int STEP_W      = $clog2(SRC_IDX_W);

    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int RESQ_DEPTH  = 2;
    localparam int RESQ_PTR_W  = $clog2(RESQ_DEPTH);

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = TGT_W;

    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_WIDTH  = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_HEIGHT = CFG_INDEX_W'(3);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    // Effective image geometry, already clamped to the legal ranges.
    typedef struct packed {
        logic [SRC_W-1:0] sw;
        logic [SRC_W-1:0] sh;
        logic [TGT_W-1:0] tw;
        logic [TGT_W-1:0] th;
    } cfg_t;

    // One classified item travelling from the front end to the back end.
    typedef struct packed {
        logic               is_emit;
        logic [PIXEL_W-1:0] pixel;
        logic [ADDR_W-1:0]  load_addr;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
        logic               row_end;
        logic               frame_end;
    } cmd_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               row_end;
        logic               frame_end;
    } res_t;

    function automatic logic [SRC_W-1:0] clamp_src(input logic [SRC_W-1:0] v);
        logic [SRC_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SRC_W'(1);
        end
        else if (v > SRC_W'(MAX_SOURCE_SIDE))
        begin
            r = SRC_W'(MAX_SOURCE_SIDE);
        end
        return r;
    endfunction

    function automatic logic [TGT_W-1:0] clamp_tgt(input logic [TGT_W-1:0] v);
        logic [TGT_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = TGT_W'(1);
        end
        else if (v > TGT_W'(MAX_TARGET_SIDE))
        begin
            r = TGT_W'(MAX_TARGET_SIDE);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/nearest_neighbor_image_scaler_top.sv =====
// Top level of the nearest-neighbor image scaler: configuration registers and wiring.
`timescale 1ns / 1ps

// The input side behaves like a queue: an item transfers when push is high and full
// is low. An item with opcode 0 loads pixel_in as the next source pixel in raster
// order; an item with opcode 1 requests the next scaled pixel of the output frame.
// The result side also behaves like a queue: while empty is low the oldest result
// sits on pixel_out, row_end and frame_end, and it transfers when pop is high.
// A load produces no result; every emit produces exactly one, in order.
// Geometry is set through the write port (cfg_we, cfg_index, cfg_data) while the
// block is idle. Zero sizes act as one, oversize values as the maximum side.
// A load is written into the source store at the edge where it leaves the command
// queue. An emit is taken from the command queue once the back end is idle and the
// result queue has space. It then passes a multiply, a restoring divider (one
// quotient bit per cycle, column and row in parallel), address, store read and
// result push. The back end takes one load per cycle while it is idle, and it
// starts a new emit only after the previous one has pushed its result.
// Reset clears the load and output counters and sets all four sizes to 256; the
// source store is not cleared, so every entry must be loaded before it is read.
// When the receiver stalls, the two-entry result queue fills, the back end stops
// starting emits, the four-entry command queue fills and full rises.
module nearest_neighbor_image_scaler_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [nnis_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [nnis_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic                              opcode,
    input  logic [nnis_pkg::PIXEL_W-1:0]      pixel_in,
    output logic                              empty,
    input  logic                              pop,
    output logic [nnis_pkg::PIXEL_W-1:0]      pixel_out,
    output logic                              row_end,
    output logic                              frame_end
);

    // Raw register values as written; clamping happens on the way to the datapath.
    logic [nnis_pkg::SRC_W-1:0] source_width_reg;
    logic [nnis_pkg::SRC_W-1:0] source_height_reg;
    logic [nnis_pkg::TGT_W-1:0] target_width_reg;
    logic [nnis_pkg::TGT_W-1:0] target_height_reg;

    nnis_pkg::cfg_t cfg;
    nnis_pkg::cmd_t front_cmd;
    nnis_pkg::cmd_t queue_cmd;
    logic           front_push;
    logic           cmdq_full;
    logic           cmdq_empty;
    logic           cmdq_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= nnis_pkg::SRC_W'(nnis_pkg::MAX_SOURCE_SIDE);
            source_height_reg <= nnis_pkg::SRC_W'(nnis_pkg::MAX_SOURCE_SIDE);
            target_width_reg  <= nnis_pkg::TGT_W'(256);
            target_height_reg <= nnis_pkg::TGT_W'(256);
        end
        else if (cfg_we)
        begin
            // Writes to an index past the last register are dropped.
            unique case (cfg_index)
                nnis_pkg::REG_SOURCE_WIDTH:  source_width_reg  <= cfg_data[nnis_pkg::SRC_W-1:0];
                nnis_pkg::REG_SOURCE_HEIGHT: source_height_reg <= cfg_data[nnis_pkg::SRC_W-1:0];
                nnis_pkg::REG_TARGET_WIDTH:  target_width_reg  <= cfg_data;
                nnis_pkg::REG_TARGET_HEIGHT: target_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.sw = nnis_pkg::clamp_src(source_width_reg);
        cfg.sh = nnis_pkg::clamp_src(source_height_reg);
        cfg.tw = nnis_pkg::clamp_tgt(target_width_reg);
        cfg.th = nnis_pkg::clamp_tgt(target_height_reg);
    end

    assign full = cmdq_full;

    // The front end classifies each transfer and stamps it with its positions.
    nnis_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .push      (push),
        .opcode    (opcode),
        .pixel_in  (pixel_in),
        .cmdq_full (cmdq_full),
        .cmd_push  (front_push),
        .cmd       (front_cmd)
    );

    nnis_cmdq u_cmdq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (front_push),
        .wr_cmd (front_cmd),
        .full   (cmdq_full),
        .rd_en  (cmdq_pop),
        .rd_cmd (queue_cmd),
        .empty  (cmdq_empty)
    );

    // The back end executes commands in order, so a load always lands in the
    // store before any later emit reads it.
    nnis_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_empty (cmdq_empty),
        .cmd       (queue_cmd),
        .cmd_pop   (cmdq_pop),
        .pop       (pop),
        .empty     (empty),
        .pixel_out (pixel_out),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

endmodule

// ===== hw/rtl/nnis_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module nnis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/nnis_front.sv =====
// Front end: accepts items, tracks load and output positions, and classifies each item.
`timescale 1ns / 1ps

module nnis_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nnis_pkg::cfg_t                cfg,
    input  logic                          push,
    input  logic                          opcode,
    input  logic [nnis_pkg::PIXEL_W-1:0]  pixel_in,
    input  logic                          cmdq_full,
    output logic                          cmd_push,
    output nnis_pkg::cmd_t                cmd
);

    logic [nnis_pkg::ADDR_W-1:0] load_pos_reg;
    logic [nnis_pkg::POS_W-1:0]  col_reg;
    logic [nnis_pkg::POS_W-1:0]  row_reg;

    logic [nnis_pkg::SIZE_W-1:0] src_size;
    logic                        load_wrap;
    logic                        row_end;
    logic                        frame_end;
    logic                        take;

    assign take     = push && !cmdq_full;
    assign cmd_push = take;

    // A position at or past the last source pixel wraps after its write.
    assign src_size  = nnis_pkg::SIZE_W'(cfg.sw) * nnis_pkg::SIZE_W'(cfg.sh);
    assign load_wrap = (nnis_pkg::SIZE_W'(load_pos_reg) + nnis_pkg::SIZE_W'(1)) >= src_size;

    assign row_end   = (nnis_pkg::TGT_W'(col_reg) + nnis_pkg::TGT_W'(1)) >= cfg.tw;
    assign frame_end = row_end
                    && ((nnis_pkg::TGT_W'(row_reg) + nnis_pkg::TGT_W'(1)) >= cfg.th);

    always_comb
    begin
        cmd.is_emit   = (opcode == nnis_pkg::OP_EMIT);
        cmd.pixel     = pixel_in;
        cmd.load_addr = load_pos_reg;
        cmd.col       = col_reg;
        cmd.row       = row_reg;
        cmd.row_end   = row_end;
        cmd.frame_end = frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else if (take)
        begin
            if (opcode == nnis_pkg::OP_LOAD)
            begin
                load_pos_reg <= load_wrap ? '0 : load_pos_reg + nnis_pkg::ADDR_W'(1);
            end
            else
            begin
                if (row_end)
                begin
                    col_reg <= '0;
                    row_reg <= frame_end ? '0 : row_reg + nnis_pkg::POS_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + nnis_pkg::POS_W'(1);
                end
            end
        end
    end

endmodule

// ===== hw/rtl/nnis_cmdq.sv =====
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module nnis_cmdq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  nnis_pkg::cmd_t wr_cmd,
    output logic           full,
    input  logic           rd_en,
    output nnis_pkg::cmd_t rd_cmd,
    output logic           empty
);

    nnis_pkg::cmd_t                   entry_reg [nnis_pkg::CMDQ_DEPTH];
    logic [nnis_pkg::CMDQ_PTR_W-1:0]  wr_ptr_reg;
    logic [nnis_pkg::CMDQ_PTR_W-1:0]  rd_ptr_reg;
    logic [nnis_pkg::CMDQ_PTR_W:0]    count_reg;
    logic                             do_wr;
    logic                             do_rd;

    assign full   = (count_reg == (nnis_pkg::CMDQ_PTR_W + 1)'(nnis_pkg::CMDQ_DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + nnis_pkg::CMDQ_PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + nnis_pkg::CMDQ_PTR_W'(1);
            end
            unique case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + (nnis_pkg::CMDQ_PTR_W + 1)'(1);
                2'b01:   count_reg <= count_reg - (nnis_pkg::CMDQ_PTR_W + 1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== hw/rtl/nnis_back.sv =====
// Back end: source store, index dividers, address generation and the result queue.
`timescale 1ns / 1ps

module nnis_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nnis_pkg::cfg_t                cfg,
    input  logic                          cmd_empty,
    input  nnis_pkg::cmd_t                cmd,
    output logic                          cmd_pop,
    input  logic                          pop,
    output logic                          empty,
    output logic [nnis_pkg::PIXEL_W-1:0]  pixel_out,
    output logic                          row_end,
    output logic                          frame_end
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ADDR,
        ST_READ,
        ST_PUSH
    } state_t;

    state_t                          state_reg;
    logic [nnis_pkg::STEP_W-1:0]     step_reg;

    // Divider lanes: x for the column, y for the row.
    logic [nnis_pkg::TGT_W-1:0]      rem_x_reg;
    logic [nnis_pkg::TGT_W-1:0]      rem_y_reg;
    logic [nnis_pkg::SRC_IDX_W-1:0]  quo_x_reg;
    logic [nnis_pkg::SRC_IDX_W-1:0]  quo_y_reg;
    logic                            sat_x_reg;
    logic                            sat_y_reg;
    logic                            row_end_reg;
    logic                            frame_end_reg;
    logic [nnis_pkg::ADDR_W-1:0]     addr_reg;

    logic [nnis_pkg::PROD_W-1:0]     prod_x;
    logic [nnis_pkg::PROD_W-1:0]     prod_y;
    logic [nnis_pkg::TGT_W:0]        trial_x;
    logic [nnis_pkg::TGT_W:0]        trial_y;
    logic [nnis_pkg::TGT_W:0]        diff_x;
    logic [nnis_pkg::TGT_W:0]        diff_y;
    logic                            fits_x;
    logic                            fits_y;
    logic [nnis_pkg::SRC_IDX_W-1:0]  src_x;
    logic [nnis_pkg::SRC_IDX_W-1:0]  src_y;
    logic [nnis_pkg::SIZE_W-1:0]     addr_sum;

    logic                            start_emit;
    logic                            do_load;
    logic [nnis_pkg::PIXEL_W-1:0]    ram_rdata;

    nnis_pkg::res_t                  res_reg [nnis_pkg::RESQ_DEPTH];
    logic [nnis_pkg::RESQ_PTR_W-1:0] res_wr_ptr_reg;
    logic [nnis_pkg::RESQ_PTR_W-1:0] res_rd_ptr_reg;
    logic [nnis_pkg::RESQ_PTR_W:0]   res_count_reg;
    logic                            res_push;
    logic                            res_pop;
    logic                            res_space;
    nnis_pkg::res_t                  res_head;

    assign res_space  = res_count_reg < (nnis_pkg::RESQ_PTR_W + 1)'(nnis_pkg::RESQ_DEPTH);
    assign do_load    = (state_reg == ST_IDLE) && !cmd_empty && !cmd.is_emit;
    assign start_emit = (state_reg == ST_IDLE) && !cmd_empty && cmd.is_emit && res_space;
    assign cmd_pop    = do_load || start_emit;

    // Numerators of the two index quotients.
    assign prod_x = nnis_pkg::PROD_W'(cmd.col) * nnis_pkg::PROD_W'(cfg.sw);
    assign prod_y = nnis_pkg::PROD_W'(cmd.row) * nnis_pkg::PROD_W'(cfg.sh);

    // One restoring step per cycle in each lane; quotient bits shift in at the bottom.
    assign trial_x = {rem_x_reg, quo_x_reg[nnis_pkg::SRC_IDX_W-1]};
    assign trial_y = {rem_y_reg, quo_y_reg[nnis_pkg::SRC_IDX_W-1]};
    assign fits_x  = trial_x >= (nnis_pkg::TGT_W + 1)'(cfg.tw);
    assign fits_y  = trial_y >= (nnis_pkg::TGT_W + 1)'(cfg.th);
    assign diff_x  = trial_x - (nnis_pkg::TGT_W + 1)'(cfg.tw);
    assign diff_y  = trial_y - (nnis_pkg::TGT_W + 1)'(cfg.th);

    // A position at or beyond its bound maps to the last source column or row.
    assign src_x    = sat_x_reg ? nnis_pkg::SRC_IDX_W'(cfg.sw - nnis_pkg::SRC_W'(1)) : quo_x_reg;
    assign src_y    = sat_y_reg ? nnis_pkg::SRC_IDX_W'(cfg.sh - nnis_pkg::SRC_W'(1)) : quo_y_reg;
    assign addr_sum = nnis_pkg::SIZE_W'(src_y) * nnis_pkg::SIZE_W'(cfg.sw)
                    + nnis_pkg::SIZE_W'(src_x);

    nnis_ram #(
        .WIDTH (nnis_pkg::PIXEL_W),
        .DEPTH (nnis_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (do_load),
        .waddr (cmd.load_addr),
        .wdata (cmd.pixel),
        .re    (state_reg == ST_READ),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start_emit)
                    begin
                        state_reg <= ST_DIV;
                        step_reg  <= '0;
                    end
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + nnis_pkg::STEP_W'(1);
                    if (step_reg == nnis_pkg::STEP_W'(nnis_pkg::SRC_IDX_W - 1))
                    begin
                        state_reg <= ST_ADDR;
                    end
                end
                ST_ADDR: state_reg <= ST_READ;
                ST_READ: state_reg <= ST_PUSH;
                ST_PUSH: state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_emit)
        begin
            rem_x_reg     <= nnis_pkg::TGT_W'(prod_x[nnis_pkg::PROD_W-1:nnis_pkg::SRC_IDX_W]);
            rem_y_reg     <= nnis_pkg::TGT_W'(prod_y[nnis_pkg::PROD_W-1:nnis_pkg::SRC_IDX_W]);
            quo_x_reg     <= prod_x[nnis_pkg::SRC_IDX_W-1:0];
            quo_y_reg     <= prod_y[nnis_pkg::SRC_IDX_W-1:0];
            sat_x_reg     <= nnis_pkg::TGT_W'(cmd.col) >= cfg.tw;
            sat_y_reg     <= nnis_pkg::TGT_W'(cmd.row) >= cfg.th;
            row_end_reg   <= cmd.row_end;
            frame_end_reg <= cmd.frame_end;
        end
        else if (state_reg == ST_DIV)
        begin
            rem_x_reg <= fits_x ? diff_x[nnis_pkg::TGT_W-1:0] : trial_x[nnis_pkg::TGT_W-1:0];
            rem_y_reg <= fits_y ? diff_y[nnis_pkg::TGT_W-1:0] : trial_y[nnis_pkg::TGT_W-1:0];
            quo_x_reg <= {quo_x_reg[nnis_pkg::SRC_IDX_W-2:0], fits_x};
            quo_y_reg <= {quo_y_reg[nnis_pkg::SRC_IDX_W-2:0], fits_y};
        end
        if (state_reg == ST_ADDR)
        begin
            addr_reg <= addr_sum[nnis_pkg::ADDR_W-1:0];
        end
    end

    // Result queue: space is checked before an emit starts, so a push always lands.
    assign res_push  = (state_reg == ST_PUSH);
    assign empty     = (res_count_reg == '0);
    assign res_pop   = pop && !empty;
    assign res_head  = res_reg[res_rd_ptr_reg];
    assign pixel_out = res_head.pixel;
    assign row_end   = res_head.row_end;
    assign frame_end = res_head.frame_end;

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_reg[res_wr_ptr_reg] <= '{pixel: ram_rdata, row_end: row_end_reg,
                                         frame_end: frame_end_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_ptr_reg <= '0;
            res_rd_ptr_reg <= '0;
            res_count_reg  <= '0;
        end
        else
        begin
            if (res_push)
            begin
                res_wr_ptr_reg <= res_wr_ptr_reg + nnis_pkg::RESQ_PTR_W'(1);
            end
            if (res_pop)
            begin
                res_rd_ptr_reg <= res_rd_ptr_reg + nnis_pkg::RESQ_PTR_W'(1);
            end
            unique case ({res_push, res_pop})
                2'b10:   res_count_reg <= res_count_reg + (nnis_pkg::RESQ_PTR_W + 1)'(1);
                2'b01:   res_count_reg <= res_count_reg - (nnis_pkg::RESQ_PTR_W + 1)'(1);
                default: res_count_reg <= res_count_reg;
            endcase
        end
    end

endmodule

// ===== tb/sv/tb_nearest_neighbor_image_scaler_top.sv =====
// Self-checking testbench for the nearest-neighbor image scaler top level.
`timescale 1ns / 1ps

// The testbench sends a stream of load and emit commands through the input queue.
// It predicts every scaled pixel with its own copy of the geometry registers, the
// source image and the raster counters, and checks each result transfer against
// the oldest prediction.
//
// Structure:
//   - The main initial block plans the commands and writes the geometry registers.
//   - A driver, clocked on the falling edge, feeds the commands to push/opcode/pixel_in.
//   - A receiver, clocked on the falling edge, drives pop with random stalls and
//     one long hold-off.
//   - A monitor, clocked on the rising edge, samples every transfer, runs the
//     predictor for accepted commands and compares the results.
//   - A watchdog ends the run when transfers stop while work is still outstanding.
//
// The source store is not cleared by reset, so the test never reads an entry that
// was not loaded. The planner keeps a second copy of the raster counters and a map
// of the loaded entries. An emit that would read an unloaded entry is turned into
// a load before it is queued.
module tb_nearest_neighbor_image_scaler_top;

    import nnis_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int RESET_SIDE    = 256;
    // A load is written into the store when it leaves the command queue. This margin
    // covers that write and also loads still queued behind the last result.
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 100;

    // The predictor keeps two copies of its counters. PLAN runs ahead while the
    // commands are queued, so that no emit reads an unloaded entry. CHECK runs on
    // accepted commands and produces the expected results.
    localparam int PLAN  = 0;
    localparam int CHECK = 1;

    typedef struct packed {
        logic               op;
        logic [PIXEL_W-1:0] pixel;
    } scaler_cmd_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   push = 1'b0;
    logic                   full;
    logic                   opcode = OP_LOAD;
    logic [PIXEL_W-1:0]     pixel_in = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [PIXEL_W-1:0]     pixel_out;
    logic                   row_end;
    logic                   frame_end;

    nearest_neighbor_image_scaler_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .pixel_in  (pixel_in),
        .empty     (empty),
        .pop       (pop),
        .pixel_out (pixel_out),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

    // The predictor's geometry registers, raw as written. They are clamped when used.
    logic [SRC_W-1:0] src_w_reg = SRC_W'(RESET_SIDE);
    logic [SRC_W-1:0] src_h_reg = SRC_W'(RESET_SIDE);
    logic [TGT_W-1:0] tgt_w_reg = TGT_W'(RESET_SIDE);
    logic [TGT_W-1:0] tgt_h_reg = TGT_W'(RESET_SIDE);

    // The predicted source image is written by the CHECK copy only. The loaded map
    // is kept by the PLAN copy only.
    logic [PIXEL_W-1:0] source_image [STORE_DEPTH];
    bit                 loaded [STORE_DEPTH];
    int unsigned        load_pos [2] = '{0, 0};
    int unsigned        next_col [2] = '{0, 0};
    int unsigned        next_row [2] = '{0, 0};

    scaler_cmd_t pending_cmds[$];
    res_t        expected_pixels[$];
    int unsigned issued_cmds = 0;
    int unsigned accepted_cmds = 0;
    int unsigned mismatches = 0;
    int unsigned stall_cycles = 0;

    // Idle rates in percent, set per phase by the main block.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // in_xfer is set by the monitor at the rising edge and read by the driver at the
    // next falling edge. The hold flags are kept by the main block and the receiver.
    bit          in_xfer = 1'b0;
    bit          hold_wanted = 1'b0;
    bit          hold_started = 1'b0;
    int unsigned hold_left = 0;

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // A size of zero acts as one, and an oversize value acts as the largest side.
    function automatic int unsigned eff_side(input int unsigned v, input int unsigned limit);
        if (v == 0)
        begin
            return 1;
        end
        if (v > limit)
        begin
            return limit;
        end
        return v;
    endfunction

    // Gives the nearest source index as an exact integer floor. A counter past its
    // bound after a size change saturates to the last source index.
    function automatic int unsigned nearest_src(input int unsigned pos, input int unsigned src,
                                                input int unsigned dst);
        int unsigned q;
        q = (pos * src) / dst;
        return (q >= src) ? src - 1 : q;
    endfunction

    function automatic int unsigned emit_address(input int ctx);
        int unsigned sw;
        int unsigned sh;
        sw = eff_side(src_w_reg, MAX_SOURCE_SIDE);
        sh = eff_side(src_h_reg, MAX_SOURCE_SIDE);
        return nearest_src(next_row[ctx], sh, eff_side(tgt_h_reg, MAX_TARGET_SIDE)) * sw
             + nearest_src(next_col[ctx], sw, eff_side(tgt_w_reg, MAX_TARGET_SIDE));
    endfunction

    // Advances one copy of the scaler by one command. Returns 1 when the command
    // yields a scaled pixel.
    function automatic bit scaler_step(input int ctx, input scaler_cmd_t cmd,
                                       output res_t result);
        int unsigned sw;
        int unsigned sh;
        int unsigned tw;
        int unsigned th;
        bit          last_col;
        bit          last_row;
        sw = eff_side(src_w_reg, MAX_SOURCE_SIDE);
        sh = eff_side(src_h_reg, MAX_SOURCE_SIDE);
        tw = eff_side(tgt_w_reg, MAX_TARGET_SIDE);
        th = eff_side(tgt_h_reg, MAX_TARGET_SIDE);
        result = '0;
        if (cmd.op == OP_LOAD)
        begin
            if (ctx == CHECK)
            begin
                source_image[load_pos[ctx]] = cmd.pixel;
            end
            else
            begin
                loaded[load_pos[ctx]] = 1'b1;
            end
            // A load position at or past the end of the source frame wraps after
            // its write.
            if (load_pos[ctx] >= sw * sh - 1)
            begin
                load_pos[ctx] = 0;
            end
            else
            begin
                load_pos[ctx] = load_pos[ctx] + 1;
            end
            return 1'b0;
        end
        if (ctx == CHECK)
        begin
            result.pixel = source_image[emit_address(ctx)];
        end
        last_col = next_col[ctx] + 1 >= tw;
        last_row = next_row[ctx] + 1 >= th;
        result.row_end   = last_col;
        result.frame_end = last_col && last_row;
        if (last_col)
        begin
            next_col[ctx] = 0;
            next_row[ctx] = last_row ? 0 : next_row[ctx] + 1;
        end
        else
        begin
            next_col[ctx] = next_col[ctx] + 1;
        end
        return 1'b1;
    endfunction

    // Queues one command for the driver. An emit that would read an unloaded entry
    // becomes a load.
    function automatic void queue_cmd(input bit want_emit, input logic [PIXEL_W-1:0] pixel);
        scaler_cmd_t cmd;
        res_t        unused;
        cmd.op    = (want_emit && loaded[emit_address(PLAN)]) ? OP_EMIT : OP_LOAD;
        cmd.pixel = pixel;
        void'(scaler_step(PLAN, cmd, unused));
        pending_cmds.push_back(cmd);
        issued_cmds = issued_cmds + 1;
    endfunction

    function automatic logic [PIXEL_W-1:0] random_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Register writes happen only while the block is idle, so the value is applied
    // to the predictor right away.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            REG_SOURCE_WIDTH:  src_w_reg = value[SRC_W-1:0];
            REG_SOURCE_HEIGHT: src_h_reg = value[SRC_W-1:0];
            REG_TARGET_WIDTH:  tgt_w_reg = value[TGT_W-1:0];
            REG_TARGET_HEIGHT: tgt_h_reg = value[TGT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every queued command is accepted and every result has arrived.
    // Then it lets trailing loads reach the store.
    task automatic wait_idle();
        while (accepted_cmds != issued_cmds || expected_pixels.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Runs one phase: it waits for idle, sets the geometry, and then queues a mix
    // of random loads and emits.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] sw, input logic [CFG_DATA_W-1:0] sh,
                             input logic [CFG_DATA_W-1:0] tw, input logic [CFG_DATA_W-1:0] th,
                             input int count, input int emit_pct);
        wait_idle();
        write_reg(REG_SOURCE_WIDTH, sw);
        write_reg(REG_SOURCE_HEIGHT, sh);
        write_reg(REG_TARGET_WIDTH, tw);
        write_reg(REG_TARGET_HEIGHT, th);
        // A write to an index past the register list must leave the geometry alone.
        if ($urandom_range(1) == 1)
        begin
            write_reg(CFG_INDEX_W'(4 + $urandom_range(11)), CFG_DATA_W'($urandom()));
        end
        repeat (count) queue_cmd($urandom_range(99) < emit_pct, random_pixel());
    endtask

    // Main sequence.
    initial
    begin : main
        int phase_no;
        send_idle_pct = 15;
        recv_idle_pct = 58;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset geometry: the extreme pixel values, then emits over loaded entries only.
        queue_cmd(1'b0, '1);
        queue_cmd(1'b0, '0);
        queue_cmd(1'b0, random_pixel());
        repeat (3) queue_cmd(1'b1, random_pixel());

        // Tiny frame: a full load, then nine emits that cover every position of the 4x2
        // output frame and cross the frame wrap.
        run_phase(3, 2, 4, 2, 0, 0);
        repeat (6) queue_cmd(1'b0, random_pixel());
        repeat (9) queue_cmd(1'b1, random_pixel());

        // Zero sizes act as one, and oversize sizes act as the maximum. The index
        // at the top of the range and an all-ones data word are ignored.
        run_phase(0, 9'h1FF, 0, 13'h1FFF, 100, 60);
        wait_idle();
        write_reg(CFG_INDEX_W'(15), '1);

        // Widest source, with an oversize target width on one row.
        run_phase(RESET_SIDE, 1, 5000, 1, 100, 60);

        // Downscale. The receiver holds off long enough for the input to fill up.
        run_phase(16, 12, 5, 3, 100, 70);
        hold_wanted = 1'b1;

        // A source width written above nine bits wraps to zero and acts as one.
        send_idle_pct = 58;
        recv_idle_pct = 15;
        run_phase(13'h200, 1, 1, 1, 70, 60);

        for (phase_no = 0; phase_no < 7; phase_no++)
        begin
            if (phase_no == 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_phase($urandom_range(9), $urandom_range(9), $urandom_range(14),
                      $urandom_range(14), 80, 55);
        end

        wait_idle();
        if (mismatches == 0)
        begin
            $display("tb_nearest_neighbor_image_scaler_top: PASS");
        end
        else
        begin
            $display("tb_nearest_neighbor_image_scaler_top: FAIL");
        end
        $finish;
    end

    // The driver holds an offered command until it transfers, and then it either
    // offers the next command or idles.
    always @(negedge clk)
    begin : driver
        scaler_cmd_t cmd;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else if (!push || in_xfer)
        begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cmd = pending_cmds.pop_front();
                push     <= 1'b1;
                opcode   <= cmd.op;
                pixel_in <= cmd.pixel;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // The receiver stalls at random. It also holds off once for a long stretch,
    // which it counts itself.
    always @(negedge clk)
    begin : receiver
        if (hold_wanted && !hold_started)
        begin
            hold_started = 1'b1;
            hold_left    = LONG_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            pop <= 1'b0;
        end
        else
        begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic void flag_mismatch(input string field_name,
                                          input logic [PIXEL_W-1:0] want_v,
                                          input logic [PIXEL_W-1:0] got_v);
        mismatches = mismatches + 1;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, field_name, want_v, got_v);
        end
    endfunction

    // The monitor samples both handshakes at the rising edge. A command transfer
    // runs the predictor. A result transfer is checked against the oldest
    // expected pixel.
    always @(posedge clk)
    begin : monitor
        scaler_cmd_t cmd;
        res_t        want;
        in_xfer = rst_n && push && !full;
        if (in_xfer)
        begin
            accepted_cmds = accepted_cmds + 1;
            cmd.op    = opcode;
            cmd.pixel = pixel_in;
            if (scaler_step(CHECK, cmd, want))
            begin
                expected_pixels.push_back(want);
            end
        end
        if (rst_n && pop && !empty)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches = mismatches + 1;
                $display("%0t: result transfer with none expected: expected nothing, got %h",
                         $time, pixel_out);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (pixel_out !== want.pixel)
                begin
                    flag_mismatch("pixel_out", want.pixel, pixel_out);
                end
                if (row_end !== want.row_end)
                begin
                    flag_mismatch("row_end", PIXEL_W'(want.row_end), PIXEL_W'(row_end));
                end
                if (frame_end !== want.frame_end)
                begin
                    flag_mismatch("frame_end", PIXEL_W'(want.frame_end), PIXEL_W'(frame_end));
                end
            end
        end
    end

    // The watchdog counts the cycles with work outstanding in which neither side
    // transfers.
    always @(posedge clk)
    begin : watchdog
        if (rst_n && (issued_cmds != accepted_cmds || expected_pixels.size() != 0)
            && !(push && !full) && !(pop && !empty))
        begin
            stall_cycles = stall_cycles + 1;
        end
        else
        begin
            stall_cycles = 0;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
            $display("tb_nearest_neighbor_image_scaler_top: FAIL");
            $finish;
        end
    end

endmodule

// ===== nearest_neighbor_image_scaler_top.f =====
hw/rtl/nnis_pkg.sv
hw/rtl/nnis_ram.sv
hw/rtl/nnis_front.sv
hw/rtl/nnis_cmdq.sv
hw/rtl/nnis_back.sv
hw/rtl/nearest_neighbor_image_scaler_top.sv
tb/sv/tb_nearest_neighbor_image_scaler_top.sv
